// ===== src/frml_pkg.sv =====
// Shared types and constants for the frame rate meter / limiter.
// Used by the channel interfaces, the serial divider and the top level.
// No dependencies.
package frml_pkg;

	// Field widths
	localparam int TS_W      = 32;   // millisecond time stamp
	localparam int FT_W      = 16;   // frame time
	localparam int FPS_W     = 22;   // frame rate, Q8
	localparam int DLY_W     = 10;   // limiter delay
	localparam int CFG_W     = 10;   // max_fps register
	localparam int BUD_W     = 10;   // frame budget, floor(1000 / cap)

	// Digit size of the serial time-stamp subtractors
	localparam int DIG_W     = 8;

	// Defaults handed to the top level parameters
	localparam int WINDOW_LEN_DEF = 10;
	localparam int SUM_W_DEF      = FT_W + $clog2(WINDOW_LEN_DEF);

	// Arithmetic constants
	localparam int MS_PER_S   = 1000;
	localparam int RATE_SCALE = 256000;    // 1000 ms * 2^8 fraction
	localparam logic [FPS_W-1:0] FPS_DEFAULT_Q8 = FPS_W'(15360);  // 60.0
	localparam logic [FPS_W-1:0] FPS_MAX_Q8     = '1;
	localparam logic [FT_W-1:0]  FT_MAX         = '1;
	localparam logic [CFG_W-1:0] MAX_FPS_RST    = CFG_W'(60);

	// Event codes
	typedef enum logic {
		OP_BEGIN = 1'b0,
		OP_END   = 1'b1
	} frml_op_t;

	// Divider control and status
	typedef enum logic {
		DIV_FPS = 1'b0,   // full-width rate division
		DIV_BUD = 1'b1    // short budget division
	} frml_div_mode_t;

	typedef struct packed {
		logic           start;
		frml_div_mode_t mode;
	} frml_div_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} frml_div_sts_t;

endpackage

// ===== src/frml_ifs.sv =====
// Valid/ready channel interfaces: frame events in, results out, max_fps writes.
// Depends on frml_pkg.
interface frml_in_if import frml_pkg::*; ();
	logic            valid;
	logic            ready;
	frml_op_t        opcode;
	logic [TS_W-1:0] now_ms;

	modport source (output valid, opcode, now_ms, input ready);
	modport sink   (input valid, opcode, now_ms, output ready);
endinterface

interface frml_out_if import frml_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [FPS_W-1:0] fps_q8;
	logic [FT_W-1:0]  frame_time_ms;
	logic [DLY_W-1:0] delay_ms;

	modport source (output valid, fps_q8, frame_time_ms, delay_ms, input ready);
	modport sink   (input valid, fps_q8, frame_time_ms, delay_ms, output ready);
endinterface

interface frml_cfg_if import frml_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] max_fps;

	modport source (output valid, max_fps, input ready);
	modport sink   (input valid, max_fps, output ready);
endinterface

// ===== src/frame_rate_meter_limiter_top.sv =====
// Frame rate meter and limiter, top level: event sequencer, frame-time ring,
// running window sum and result register.
// Depends on frml_pkg, frml_ifs (channel interfaces) and frml_div.
//
//   channel  | dir | payload                                  | accepted when
//   ---------+-----+------------------------------------------+--------------------
//   events   | in  | opcode, now_ms                           | valid && ready
//   results  | out | fps_q8, frame_time_ms, delay_ms          | valid && ready
//   cfg      | in  | max_fps                                  | valid && ready
//
// A begin item is absorbed in the cycle it is taken. An end item passes through
// two 8-bit-per-cycle time-stamp subtractors, then the shared bit-serial divider
// for the rate and the budget.
// One item is worked on at a time; the result register lets the next item
// start while the previous result waits for results.ready.
// Reset clears the control registers, not the ring, which reads as zero until filled.
module frame_rate_meter_limiter_top import frml_pkg::*; #(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	frml_in_if.sink    events,
	frml_out_if.source results,
	frml_cfg_if.sink   cfg
);

	localparam int SUM_W     = FT_W + $clog2(WINDOW_LEN);
	localparam int CNT_W     = $clog2(WINDOW_LEN + 1);
	localparam int IDX_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int NUM_W     = $clog2(RATE_SCALE * WINDOW_LEN + 1);
	localparam int DVD_W     = (NUM_W > FPS_W) ? NUM_W : FPS_W;
	localparam int DVS_W     = (SUM_W > BUD_W) ? SUM_W : BUD_W;
	localparam int SUB_STEPS = TS_W / DIG_W;
	localparam int SC_W      = (SUB_STEPS > 1) ? $clog2(SUB_STEPS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUB,
		S_UPD,
		S_FSET,
		S_FDIV,
		S_BSET,
		S_BDIV,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [SC_W-1:0]    dig_cnt_q;
	logic [CFG_W-1:0]   max_fps_q;
	logic [TS_W-1:0]    begin_q;
	logic [TS_W-1:0]    prev_end_q;
	logic               seen_q;
	logic               first_q;
	logic [IDX_W-1:0]   wr_idx_q;
	logic [CNT_W-1:0]   fill_q;
	logic [SUM_W-1:0]   sum_q;
	logic [FT_W-1:0]    ft_q;
	logic [FPS_W-1:0]   fps_q;
	logic [BUD_W-1:0]   budget_q;
	logic               out_valid_q;
	logic [FPS_W-1:0]   out_fps_q;
	logic [FT_W-1:0]    out_ft_q;
	logic [DLY_W-1:0]   out_dly_q;

	// Serial subtractor operands and results
	logic [TS_W-1:0]    now_sh_q;
	logic [TS_W-1:0]    pe_sh_q;
	logic [TS_W-1:0]    fb_sh_q;
	logic [TS_W-1:0]    ft_diff_q;
	logic [TS_W-1:0]    el_diff_q;
	logic               c_ft_q;
	logic               c_el_q;

	// Frame-time ring
	logic [FT_W-1:0]    ring_q [WINDOW_LEN];
	logic [FT_W-1:0]    ring_rd_q;

	logic               accept;
	logic               accept_end;
	logic [DIG_W:0]     ft_dig;
	logic [DIG_W:0]     el_dig;
	logic [FT_W-1:0]    ft_new;
	logic [FT_W-1:0]    ft_old;
	logic [CFG_W-1:0]   cap;
	logic [DLY_W-1:0]   delay;
	logic               out_free;

	frml_div_cmd_t      div_cmd;
	frml_div_sts_t      div_sts;
	logic [DVD_W-1:0]   div_dvd;
	logic [DVS_W-1:0]   div_dvs;
	logic [DVD_W-1:0]   div_quo;

	// Handshakes
	assign events.ready = (state_q == S_IDLE);
	assign accept       = events.valid && events.ready;
	assign accept_end   = accept && (events.opcode == OP_END);
	assign cfg.ready    = 1'b1;
	assign out_free     = !out_valid_q || results.ready;

	// One digit of each time-stamp difference per cycle
	assign ft_dig = {1'b0, now_sh_q[DIG_W-1:0]} + {1'b0, ~pe_sh_q[DIG_W-1:0]}
		+ {{DIG_W{1'b0}}, c_ft_q};
	assign el_dig = {1'b0, now_sh_q[DIG_W-1:0]} + {1'b0, ~fb_sh_q[DIG_W-1:0]}
		+ {{DIG_W{1'b0}}, c_el_q};

	// Saturated frame time; the slot being replaced is zero until the ring has filled
	always_comb begin
		if (first_q) begin
			ft_new = '0;
		end else if (|ft_diff_q[TS_W-1:FT_W]) begin
			ft_new = FT_MAX;
		end else begin
			ft_new = ft_diff_q[FT_W-1:0];
		end
		ft_old = (fill_q == CNT_W'(WINDOW_LEN)) ? ring_rd_q : '0;
	end

	// Limiter delay from budget and elapsed time
	always_comb begin
		if (|el_diff_q[TS_W-1:BUD_W]) begin
			delay = '0;
		end else if (budget_q > el_diff_q[BUD_W-1:0]) begin
			delay = DLY_W'(budget_q - el_diff_q[BUD_W-1:0]);
		end else begin
			delay = '0;
		end
	end

	// Divider operands
	assign cap          = (max_fps_q == '0) ? CFG_W'(1) : max_fps_q;
	assign div_cmd.start = ((state_q == S_FSET) && (sum_q != '0)) || (state_q == S_BSET);
	assign div_cmd.mode  = (state_q == S_BSET) ? DIV_BUD : DIV_FPS;
	always_comb begin
		if (state_q == S_BSET) begin
			div_dvd = DVD_W'(MS_PER_S) << (DVD_W - BUD_W);
			div_dvs = DVS_W'(cap);
		end else begin
			div_dvd = DVD_W'(RATE_SCALE * fill_q);
			div_dvs = DVS_W'(sum_q);
		end
	end

	frml_div #(
		.DVD_W (DVD_W),
		.DVS_W (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.sts      (div_sts),
		.quotient (div_quo)
	);

	// Sequencer, block state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dig_cnt_q   <= '0;
			max_fps_q   <= MAX_FPS_RST;
			begin_q     <= '0;
			prev_end_q  <= '0;
			seen_q      <= 1'b0;
			first_q     <= 1'b0;
			wr_idx_q    <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			ft_q        <= '0;
			fps_q       <= '0;
			budget_q    <= '0;
			out_valid_q <= 1'b0;
			out_fps_q   <= '0;
			out_ft_q    <= '0;
			out_dly_q   <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				max_fps_q <= cfg.max_fps;
			end
			if (out_valid_q && results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (events.opcode == OP_END) begin
							first_q    <= !seen_q;
							seen_q     <= 1'b1;
							prev_end_q <= events.now_ms;
							dig_cnt_q  <= '0;
							state_q    <= S_SUB;
						end else begin
							begin_q <= events.now_ms;
						end
					end
				end
				S_SUB: begin
					dig_cnt_q <= dig_cnt_q + 1'b1;
					if (dig_cnt_q == SC_W'(SUB_STEPS - 1)) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					ft_q  <= ft_new;
					sum_q <= sum_q - SUM_W'(ft_old) + SUM_W'(ft_new);
					wr_idx_q <= (wr_idx_q == IDX_W'(WINDOW_LEN - 1)) ? '0 : wr_idx_q + 1'b1;
					if (fill_q != CNT_W'(WINDOW_LEN)) begin
						fill_q <= fill_q + 1'b1;
					end
					state_q <= S_FSET;
				end
				S_FSET: begin
					if (sum_q == '0) begin
						fps_q   <= FPS_DEFAULT_Q8;
						state_q <= S_BSET;
					end else begin
						state_q <= S_FDIV;
					end
				end
				S_FDIV: begin
					if (div_sts.done) begin
						fps_q   <= (div_quo > DVD_W'(FPS_MAX_Q8)) ? FPS_MAX_Q8
							: div_quo[FPS_W-1:0];
						state_q <= S_BSET;
					end
				end
				S_BSET: begin
					state_q <= S_BDIV;
				end
				S_BDIV: begin
					if (div_sts.done) begin
						budget_q <= div_quo[BUD_W-1:0];
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_fps_q   <= fps_q;
						out_ft_q    <= ft_q;
						out_dly_q   <= delay;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Digit-serial subtractors: now - prev_end and now - frame_begin
	always_ff @(posedge clk) begin
		if (accept_end) begin
			now_sh_q <= events.now_ms;
			pe_sh_q  <= prev_end_q;
			fb_sh_q  <= begin_q;
			c_ft_q   <= 1'b1;
			c_el_q   <= 1'b1;
		end else if (state_q == S_SUB) begin
			now_sh_q  <= now_sh_q >> DIG_W;
			pe_sh_q   <= pe_sh_q >> DIG_W;
			fb_sh_q   <= fb_sh_q >> DIG_W;
			ft_diff_q <= {ft_dig[DIG_W-1:0], ft_diff_q[TS_W-1:DIG_W]};
			el_diff_q <= {el_dig[DIG_W-1:0], el_diff_q[TS_W-1:DIG_W]};
			c_ft_q    <= ft_dig[DIG_W];
			c_el_q    <= el_dig[DIG_W];
		end
	end

	// Ring memory: read the slot to be replaced at accept, write it in the update step
	always_ff @(posedge clk) begin
		if (accept_end) begin
			ring_rd_q <= ring_q[wr_idx_q];
		end
		if (state_q == S_UPD) begin
			ring_q[wr_idx_q] <= ft_new;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.fps_q8        = out_fps_q;
	assign results.frame_time_ms = out_ft_q;
	assign results.delay_ms      = out_dly_q;

`ifndef SYNTHESIS
	a_fill_tracks_index: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q < CNT_W'(WINDOW_LEN)) |-> (CNT_W'(wr_idx_q) == fill_q))
		else $error("ring write index out of step with fill count");
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_idx_q <= IDX_W'(WINDOW_LEN - 1))
		else $error("ring write index out of range");
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		events.ready |-> !div_sts.busy)
		else $error("new item taken while divider is running");
	a_hold_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !results.ready) |=> state_q == S_DONE)
		else $error("finished item dropped while result register is full");
`endif

endmodule

// ===== src/frml_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Rate mode runs DVD_W steps, budget mode runs BUD_W steps on a left-aligned dividend.
// Depends on frml_pkg.
module frml_div import frml_pkg::*; #(
	parameter int DVD_W = FPS_W,
	parameter int DVS_W = SUM_W_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  frml_div_cmd_t     cmd,
	input  logic [DVD_W-1:0]  dividend,
	input  logic [DVS_W-1:0]  divisor,
	output frml_div_sts_t     sts,
	output logic [DVD_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVD_W-1:0]  num_q;
	logic [DVD_W-1:0]  quo_q;

	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              ge;

	// One trial subtraction per step
	assign trial = {rem_q, num_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (cmd.mode == DIV_BUD) ? CNT_W'(BUD_W) : CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift registers for remainder, dividend and quotient
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			num_q <= dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			num_q <= {num_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q)
		else $error("divider started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a finished run");
	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("divider busy with zero step count");
`endif

endmodule

// ===== dv/frame_rate_meter_limiter_top_tb.sv =====
// Self-checking testbench for frame_rate_meter_limiter_top: drives frame events and
// max_fps writes, predicts frame time, averaged rate and limiter delay per end item.
// Depends on frml_pkg, frml_ifs and the RTL of the top level.
`timescale 1ns / 1ps

module frame_rate_meter_limiter_top_tb;
	import frml_pkg::*;

	localparam int WINDOW       = WINDOW_LEN_DEF;
	localparam int DRAIN_CYCLES = 60;        // drain wait after the last owed result
	localparam int HOLD_CYCLES  = 600;       // long receiver hold-off
	localparam int LIMIT_CYCLES = 3000000;
	localparam int PHASE_ITEMS  = 220;

	// Expected result of one end item
	typedef struct packed {
		logic [FPS_W-1:0] fps;
		logic [FT_W-1:0]  ft;
		logic [DLY_W-1:0] dly;
	} frame_result_t;

	// Tracks the block's state and holds the results still owed
	class frame_stats_tracker;
		logic [CFG_W-1:0] fps_cap;
		logic [TS_W-1:0]  begin_ts;
		logic [TS_W-1:0]  last_end_ts;
		bit               had_end;
		logic [FT_W-1:0]  ring [WINDOW];
		int unsigned      wr_idx;
		int unsigned      filled;
		int unsigned      sum;
		frame_result_t    owed_results [$];
		int               errors;

		function new();
			fps_cap     = MAX_FPS_RST;
			begin_ts    = '0;
			last_end_ts = '0;
			had_end     = 0;
			foreach (ring[i]) ring[i] = '0;
			wr_idx      = 0;
			filled      = 0;
			sum         = 0;
			errors      = 0;
		endfunction

		function void set_max_fps(logic [CFG_W-1:0] v);
			fps_cap = v;
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		// Accepted input item: update state, queue the result of an end
		function void note_event(frml_op_t op, logic [TS_W-1:0] stamp);
			logic [TS_W-1:0]   diff;
			logic [TS_W-1:0]   elapsed;
			longint unsigned   q;
			int unsigned       cap;
			int unsigned       budget;
			frame_result_t     r;
			if (op == OP_BEGIN) begin
				begin_ts = stamp;
				return;
			end
			// frame time, saturated; zero on the first end
			diff = stamp - last_end_ts;
			if (!had_end)
				r.ft = '0;
			else
				r.ft = (diff > FT_MAX) ? FT_MAX : diff[FT_W-1:0];
			had_end     = 1;
			last_end_ts = stamp;
			// ring and running sum
			sum         = sum - ring[wr_idx] + r.ft;
			ring[wr_idx] = r.ft;
			wr_idx      = (wr_idx + 1) % WINDOW;
			if (filled < WINDOW)
				filled++;
			// averaged rate in Q8
			if (sum == 0) begin
				r.fps = FPS_DEFAULT_Q8;
			end else begin
				q = (64'(RATE_SCALE) * 64'(filled)) / 64'(sum);
				r.fps = (q > FPS_MAX_Q8) ? FPS_MAX_Q8 : q[FPS_W-1:0];
			end
			// limiter delay; a zero cap counts as one
			cap     = (fps_cap == 0) ? 1 : fps_cap;
			budget  = MS_PER_S / cap;
			elapsed = stamp - begin_ts;
			r.dly   = (budget > elapsed) ? DLY_W'(budget - elapsed) : '0;
			owed_results.push_back(r);
		endfunction

		// Accepted result: compare with the oldest one owed
		function void check_result(logic [FPS_W-1:0] fps, logic [FT_W-1:0] ft,
				logic [DLY_W-1:0] dly);
			frame_result_t e;
			if (owed_results.size() == 0) begin
				$error("result with none expected: fps_q8 %0d frame_time_ms %0d delay_ms %0d",
					fps, ft, dly);
				errors++;
				return;
			end
			e = owed_results.pop_front();
			if (fps !== e.fps) begin
				$error("fps_q8 mismatch: expected %0d, actual %0d", e.fps, fps);
				errors++;
			end
			if (ft !== e.ft) begin
				$error("frame_time_ms mismatch: expected %0d, actual %0d", e.ft, ft);
				errors++;
			end
			if (dly !== e.dly) begin
				$error("delay_ms mismatch: expected %0d, actual %0d", e.dly, dly);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	frml_in_if  ev ();
	frml_out_if res ();
	frml_cfg_if cfg_ch ();

	frame_rate_meter_limiter_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.events (ev),
		.results(res),
		.cfg    (cfg_ch)
	);

	frame_stats_tracker tracker;
	bit              tx_idle_en;
	bit              rx_idle_en;
	int              hold_reqs;
	int              cycle_count;
	logic [TS_W-1:0] t_ms;

	// Clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Timeout
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Gap length: mostly none or short, now and then long
	function automatic int pick_gap(bit enable);
		int r;
		if (!enable)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(20, 100);
	endfunction

	// Result side: check accepted items, then pick ready for the next cycle
	initial begin
		int stall_left;
		int hold_seen;
		int gap;
		stall_left = 0;
		hold_seen  = 0;
		res.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res.valid && res.ready)
				tracker.check_result(res.fps_q8, res.frame_time_ms, res.delay_ms);
			if (hold_seen != hold_reqs) begin
				hold_seen  = hold_reqs;
				stall_left = HOLD_CYCLES;
			end
			gap = (stall_left == 0) ? pick_gap(rx_idle_en) : 0;
			if (stall_left > 0) begin
				stall_left--;
				res.ready <= 1'b0;
			end else if (gap > 0) begin
				stall_left = gap - 1;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// One event item through the handshake, then a random gap
	task automatic send_event(input frml_op_t op, input logic [TS_W-1:0] stamp);
		int gap;
		ev.valid  <= 1'b1;
		ev.opcode <= op;
		ev.now_ms <= stamp;
		@(posedge clk);
		while (!ev.ready)
			@(posedge clk);
		tracker.note_event(op, stamp);
		gap = pick_gap(tx_idle_en);
		if (gap > 0) begin
			ev.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and wait for every owed result
	task automatic wait_results();
		ev.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// Register write, only with the block idle
	task automatic write_max_fps(input logic [CFG_W-1:0] v);
		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_ch.valid   <= 1'b1;
		cfg_ch.max_fps <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		tracker.set_max_fps(v);
		@(posedge clk);
	endtask

	// Mostly well-formed begin/end pairs, some noise and broken sequences;
	// the caller drops valid afterwards
	task automatic run_phase(input int n_items, input bit idle, input bit hold);
		int sent;
		int r;
		int w;
		sent       = 0;
		tx_idle_en = idle;
		rx_idle_en = idle;
		if (hold)
			hold_reqs++;
		while (sent < n_items) begin
			if (hold && sent >= n_items / 2 && sent < n_items / 2 + 2)
				wait_results();
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 199) == 0)
				t_ms = $urandom();
			if (r < 75) begin
				t_ms += $urandom_range(0, 40);
				send_event(OP_BEGIN, t_ms);
				w = $urandom_range(0, 99);
				if (w < 70)
					t_ms += $urandom_range(0, 40);
				else if (w < 95)
					t_ms += $urandom_range(0, 1100);
				else
					t_ms += $urandom_range(0, 200000);
				send_event(OP_END, t_ms);
				sent += 2;
			end else if (r < 85) begin
				send_event(frml_op_t'($urandom_range(0, 1)), $urandom());
				sent++;
			end else if (r < 92) begin
				// end with no fresh begin
				t_ms += $urandom_range(0, 30);
				send_event(OP_END, t_ms);
				sent++;
			end else if (r < 96) begin
				// two begins, then an end
				send_event(OP_BEGIN, t_ms + $urandom_range(0, 20));
				t_ms += $urandom_range(0, 30);
				send_event(OP_BEGIN, t_ms);
				t_ms += $urandom_range(0, 30);
				send_event(OP_END, t_ms);
				sent += 3;
			end else begin
				// begin stamped after the end, elapsed wraps
				send_event(OP_BEGIN, t_ms + $urandom_range(1, 50));
				send_event(OP_END, t_ms);
				sent += 2;
			end
		end
	endtask

	// Main sequence
	initial begin
		tracker        = new();
		tx_idle_en     = 0;
		rx_idle_en     = 0;
		hold_reqs      = 0;
		t_ms           = $urandom();
		arst_n          = 1'b0;
		ev.valid       <= 1'b0;
		ev.opcode      <= OP_BEGIN;
		ev.now_ms      <= '0;
		cfg_ch.valid   <= 1'b0;
		cfg_ch.max_fps <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: end before any begin, stamp extremes, saturation, wrap
		send_event(OP_END,   32'h0000_0005);
		send_event(OP_BEGIN, 32'hFFFF_FFFF);
		send_event(OP_END,   32'hFFFF_FFFF);
		send_event(OP_END,   32'hFFFF_FFFF);
		send_event(OP_BEGIN, 32'h0000_0003);
		send_event(OP_END,   32'h0000_0000);
		send_event(OP_BEGIN, 32'hAAAA_AAAA);
		send_event(OP_END,   32'h5555_5555);
		send_event(OP_BEGIN, 32'h0000_0000);
		send_event(OP_END,   32'h8000_0000);
		// a full window of zero frame times brings the sum back to zero
		send_event(OP_BEGIN, 32'd100);
		repeat (WINDOW + 1) send_event(OP_END, 32'd100);

		// Random phases over several caps, extremes and out-of-range ones included
		write_max_fps(CFG_W'(1));
		run_phase(PHASE_ITEMS, 1, 0);
		write_max_fps(CFG_W'(1000));
		run_phase(PHASE_ITEMS, 1, 0);
		write_max_fps(CFG_W'(0));
		run_phase(PHASE_ITEMS, 0, 1);
		write_max_fps('1);
		run_phase(PHASE_ITEMS, 1, 0);
		write_max_fps(MAX_FPS_RST);
		run_phase(PHASE_ITEMS, 0, 0);
		write_max_fps(CFG_W'($urandom_range(1, 1000)));
		run_phase(PHASE_ITEMS, 1, 0);
		write_max_fps(CFG_W'($urandom()));
		run_phase(PHASE_ITEMS, 1, 1);
		write_max_fps(CFG_W'(30));
		run_phase(PHASE_ITEMS, 1, 0);
		write_max_fps(CFG_W'($urandom_range(1, 120)));
		run_phase(PHASE_ITEMS, 1, 0);

		// Drain and finish
		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
